// ===== hdl/slr_pkg.sv =====
// Package with shared types, constants and helpers for the shelf rectangle packer.
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

  // Field widths
  localparam int DIM_W  = 15;
  localparam int AREA_W = 29;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Largest dimension honored; larger sizes are clamped to it
  localparam int MAX_DIM = 16384;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [AREA_W-1:0] area_t;

  localparam dim_t  DIM_SAT     = {DIM_W{1'b1}};
  localparam area_t AREA_MAX    = {AREA_W{1'b1}};
  localparam dim_t  ATLAS_RESET = dim_t'(2048);

  // Register indexes, selected by paddr[2]
  localparam logic REG_ATLAS_WIDTH  = 1'b0;
  localparam logic REG_ATLAS_HEIGHT = 1'b1;

  // Clamp a dimension to MAX_DIM
  function automatic dim_t clamp_dim(input dim_t v);
    clamp_dim = (v > MAX_DIM) ? dim_t'(MAX_DIM) : v;
  endfunction

  // Saturating add of two dimensions
  function automatic dim_t sat_add(input dim_t a, input dim_t b);
    logic [DIM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[DIM_W] ? DIM_SAT : s[DIM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/shelf_rectangle_packer.sv =====
// Shelf next-fit rectangle packer with rotation: input register, placement logic, result register.
// An accepted rectangle enters the result register, raising out_valid, once it is free or draining.
// Throughput: one rectangle per cycle while out_ready holds; the cursor, shelf and area registers
// are updated in the same cycle the placement is computed, so each item sees the state left by
// the one before.
// Reset (synchronous, rst_n low): packing state clears, atlas returns to 2048 x 2048, stages empty.
`timescale 1ns / 1ps
`default_nettype none

module shelf_rectangle_packer (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [slr_pkg::DIM_W-1:0]          in_rect_width,
  input  wire  [slr_pkg::DIM_W-1:0]          in_rect_height,
  input  wire                                in_first_of_pass,
  // Result channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               out_placed,
  output logic                               out_rotated,
  output logic [slr_pkg::DIM_W-1:0]          out_pos_x,
  output logic [slr_pkg::DIM_W-1:0]          out_pos_y,
  output logic [slr_pkg::DIM_W-1:0]          out_placed_w,
  output logic [slr_pkg::DIM_W-1:0]          out_placed_h,
  output logic [slr_pkg::AREA_W-1:0]         out_area_used,
  // Configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [slr_pkg::ADDR_W-1:0]         paddr,
  input  wire  [slr_pkg::DATA_W-1:0]         pwdata,
  output logic [slr_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  // Configuration registers
  slr_pkg::dim_t atlas_w_r;
  slr_pkg::dim_t atlas_h_r;
  logic          cfg_wr;

  // Input stage
  logic          in_v_r;
  slr_pkg::dim_t in_w_r;
  slr_pkg::dim_t in_h_r;
  logic          in_first_r;

  // Packing state
  slr_pkg::dim_t  cursor_x_r, cursor_x_nxt;
  slr_pkg::dim_t  cursor_y_r, cursor_y_nxt;
  slr_pkg::dim_t  shelf_h_r,  shelf_h_nxt;
  slr_pkg::area_t used_area_r, used_area_nxt;

  // Result stage
  logic           out_v_r;
  logic           placed_r, placed_nxt;
  logic           rotated_r, rotated_nxt;
  slr_pkg::dim_t  pos_x_r, pos_x_nxt;
  slr_pkg::dim_t  pos_y_r, pos_y_nxt;
  slr_pkg::dim_t  pw_r, pw_nxt;
  slr_pkg::dim_t  ph_r, ph_nxt;

  logic advance;

  // Placement working values
  slr_pkg::dim_t  w0, h0, aw, ah;
  slr_pkg::dim_t  cx, cy, sh;
  slr_pkg::area_t ua;
  slr_pkg::dim_t  w1, h1, w2, h2, w3, h3;
  slr_pkg::dim_t  cx2, cy2, sh2;
  logic           rot1, rot2, rot3;
  logic           new_shelf, no_fit2, fail;
  logic [slr_pkg::DIM_W:0]    cx_sum, y_sum2, y_sum3;
  logic [2*slr_pkg::DIM_W-1:0] rect_area;
  logic [slr_pkg::AREA_W:0]   area_sum;

  // APB: always ready, write in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atlas_w_r <= slr_pkg::ATLAS_RESET;
      atlas_h_r <= slr_pkg::ATLAS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        slr_pkg::REG_ATLAS_WIDTH:  atlas_w_r <= pwdata[slr_pkg::DIM_W-1:0];
        slr_pkg::REG_ATLAS_HEIGHT: atlas_h_r <= pwdata[slr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (paddr[2])
      slr_pkg::REG_ATLAS_WIDTH:  prdata = {{(slr_pkg::DATA_W-slr_pkg::DIM_W){1'b0}}, atlas_w_r};
      slr_pkg::REG_ATLAS_HEIGHT: prdata = {{(slr_pkg::DATA_W-slr_pkg::DIM_W){1'b0}}, atlas_h_r};
      default:                   prdata = '0;
    endcase
  end

  // Handshake: move the input stage forward whenever the result register is free or draining
  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign out_valid = out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_w_r     <= in_rect_width;
      in_h_r     <= in_rect_height;
      in_first_r <= in_first_of_pass;
    end
  end

  // Place one rectangle against the current shelf
  always_comb begin
    w0 = slr_pkg::clamp_dim(in_w_r);
    h0 = slr_pkg::clamp_dim(in_h_r);
    aw = slr_pkg::clamp_dim(atlas_w_r);
    ah = slr_pkg::clamp_dim(atlas_h_r);

    // Start of pass clears the packing state
    cx = in_first_r ? '0 : cursor_x_r;
    cy = in_first_r ? '0 : cursor_y_r;
    sh = in_first_r ? '0 : shelf_h_r;
    ua = in_first_r ? '0 : used_area_r;

    // Orient to suit the current shelf
    rot1 = ((w0 > h0) && (w0 < sh)) || ((w0 < h0) && (h0 > sh));
    w1   = rot1 ? h0 : w0;
    h1   = rot1 ? w0 : h0;

    // Open a new shelf on horizontal overflow, long edge flat
    cx_sum    = {1'b0, cx} + {1'b0, w1};
    new_shelf = cx_sum > {1'b0, aw};
    cx2 = new_shelf ? '0 : cx;
    cy2 = new_shelf ? slr_pkg::sat_add(cy, sh) : cy;
    sh2 = new_shelf ? '0 : sh;
    rot2 = rot1;
    w2 = w1;
    h2 = h1;
    if (new_shelf && (w1 < h1)) begin
      rot2 = !rot1;
      w2   = h1;
      h2   = w1;
    end

    // Fall back to the other orientation
    y_sum2  = {1'b0, cy2} + {1'b0, h2};
    no_fit2 = (w2 > aw) || (y_sum2 > {1'b0, ah});
    rot3 = no_fit2 ? !rot2 : rot2;
    w3   = no_fit2 ? h2 : w2;
    h3   = no_fit2 ? w2 : h2;
    y_sum3 = {1'b0, cy2} + {1'b0, h3};
    fail   = (w3 > aw) || (y_sum3 > {1'b0, ah});

    rect_area = w3 * h3;
    area_sum  = {1'b0, ua} + (slr_pkg::AREA_W+1)'(rect_area);

    if (fail) begin
      placed_nxt    = 1'b0;
      rotated_nxt   = 1'b0;
      pos_x_nxt     = '0;
      pos_y_nxt     = '0;
      pw_nxt        = '0;
      ph_nxt        = '0;
      cursor_x_nxt  = cx2;
      shelf_h_nxt   = sh2;
      used_area_nxt = ua;
    end else begin
      placed_nxt    = 1'b1;
      rotated_nxt   = rot3;
      pos_x_nxt     = cx2;
      pos_y_nxt     = cy2;
      pw_nxt        = w3;
      ph_nxt        = h3;
      cursor_x_nxt  = slr_pkg::sat_add(cx2, w3);
      shelf_h_nxt   = (h3 > sh2) ? h3 : sh2;
      used_area_nxt = area_sum[slr_pkg::AREA_W] ? slr_pkg::AREA_MAX
                                                : area_sum[slr_pkg::AREA_W-1:0];
    end
    cursor_y_nxt = cy2;
  end

  // Commit packing state when the transaction moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      shelf_h_r   <= '0;
      used_area_r <= '0;
    end else if (advance) begin
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      shelf_h_r   <= shelf_h_nxt;
      used_area_r <= used_area_nxt;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      placed_r  <= placed_nxt;
      rotated_r <= rotated_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      pw_r      <= pw_nxt;
      ph_r      <= ph_nxt;
    end
  end

  assign out_placed    = placed_r;
  assign out_rotated   = rotated_r;
  assign out_pos_x     = pos_x_r;
  assign out_pos_y     = pos_y_r;
  assign out_placed_w  = pw_r;
  assign out_placed_h  = ph_r;
  assign out_area_used = used_area_r;

  // A failed placement reports zeroed geometry
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !placed_r) |-> (pos_x_r == '0 && pos_y_r == '0 &&
                                pw_r == '0 && ph_r == '0 && !rotated_r))
    else $error("failed placement carries nonzero geometry");

  // Used area never shrinks within a pass
  a_area_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_first_r) |=> (used_area_r >= $past(used_area_r)))
    else $error("used area decreased within a pass");

  // An empty input stage always takes a transaction
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_ready)
    else $error("input stalled while empty");

  // State only moves when a transaction advances
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(cursor_x_r) && $stable(cursor_y_r) && $stable(used_area_r)))
    else $error("packing state changed without a transaction");

endmodule

`default_nettype wire
